// ===== design/tbcp_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tbcp_pkg: shared types and constants for the padded Treyfer block engine
// Holds the sequencer state type, register indexes, block geometry and the
// byte substitution table.
// -----------------------------------------------------------------------------
package tbcp_pkg;

   // block geometry
   localparam int unsigned BLK_BYTES = 8;
   localparam int unsigned BLK_W     = 8 * BLK_BYTES;
   localparam int unsigned CNT_BYTES_W = 4;

   // configuration register indexes
   localparam logic CSR_KEY  = 1'b0;
   localparam logic CSR_MODE = 1'b1;

   // key value after reset: ASCII "password", byte 0 in bits 7:0
   localparam logic [BLK_W-1:0] KEY_RESET = 64'h6472_6f77_7373_6170;

   // padding byte of the trailing block that follows a full final block
   localparam logic [7:0] PAD_FULL = 8'h08;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_EMIT
   } state_type;

   // byte substitution table
   localparam logic [7:0] SBOX [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

endpackage

// ===== design/treyfer_block_crypt_padded.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// treyfer_block_crypt_padded: Treyfer block engine with block padding
// Encrypts with padding or decrypts with pad removal, one byte step per
// cycle through a single shared substitution unit.
// -----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  req_     | in        | req_valid / req_ready | block_in, byte_count, last_block
//  rsp_     | out       | rsp_valid / rsp_ready | block_out, valid_bytes, last_out
//  csr_     | in        | csr_we                | csr_index, csr_wdata
//
//  One request takes a load step, ROUNDS*8 byte steps (256 at the default)
//  and an emit step. The byte step chain through the one substitution table
//  sets the run time. A full final encrypt block adds a second pass for the
//  padding block: ROUNDS*8 byte steps and an emit step, with no load step.
//  Reset is synchronous and restores the key and mode registers.
//  The result register frees the core: a stalled rsp_ side only holds the
//  engine when a new result is ready to be written over an untaken one.
// -----------------------------------------------------------------------------
module treyfer_block_crypt_padded #(
   parameter int unsigned ROUNDS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [tbcp_pkg::BLK_W-1:0] req_block_in,
   input  logic [3:0]                 req_byte_count,
   input  logic                       req_last_block,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [tbcp_pkg::BLK_W-1:0] rsp_block_out,
   output logic [3:0]                 rsp_valid_bytes,
   output logic                       rsp_last_out,
   // configuration port
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [tbcp_pkg::BLK_W-1:0] csr_wdata
);

   localparam int unsigned STEPS = ROUNDS * tbcp_pkg::BLK_BYTES;
   localparam int unsigned CNT_W = $clog2(STEPS);

   // registers
   tbcp_pkg::state_type         state_ff, state_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [tbcp_pkg::BLK_W-1:0]  blk_ff, blk_in;
   logic                        last_ff, last_in;
   logic                        pad_ff, pad_in;
   logic [tbcp_pkg::BLK_W-1:0]  key_ff, key_in;
   logic                        mode_ff, mode_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tbcp_pkg::BLK_W-1:0]  rsp_block_ff, rsp_block_in;
   logic [3:0]                  rsp_bytes_ff, rsp_bytes_in;
   logic                        rsp_last_ff, rsp_last_in;

   // control and datapath
   logic                        accept;
   logic                        out_free;
   logic                        last_step;
   logic                        do_emit;
   logic [2:0]                  bi;
   logic [2:0]                  nx;
   logic [7:0]                  t_i;
   logic [7:0]                  k_i;
   logic [7:0]                  t_nx;
   logic [7:0]                  s_val;
   logic [7:0]                  sum_enc;
   logic [7:0]                  new_byte;
   logic [tbcp_pkg::BLK_W-1:0]  step_blk;
   logic [tbcp_pkg::BLK_W-1:0]  load_blk;
   logic [3:0]                  n_sat;
   logic [7:0]                  pad_byte;
   logic [7:0]                  pad_val;
   logic [3:0]                  emit_bytes;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_step = (cnt_ff == CNT_W'(STEPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tbcp_pkg::ST_IDLE: begin
            if (req_valid) state_in = tbcp_pkg::ST_RUN;
         end
         tbcp_pkg::ST_RUN: begin
            if (last_step) state_in = tbcp_pkg::ST_EMIT;
         end
         tbcp_pkg::ST_EMIT: begin
            if (out_free) state_in = pad_ff ? tbcp_pkg::ST_RUN : tbcp_pkg::ST_IDLE;
         end
         default: state_in = tbcp_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      do_emit   = 1'b0;
      unique case (state_ff)
         tbcp_pkg::ST_IDLE: req_ready = 1'b1;
         tbcp_pkg::ST_RUN:  req_ready = 1'b0;
         tbcp_pkg::ST_EMIT: do_emit   = out_free;
         default:           req_ready = 1'b0;
      endcase
   end

   // shared byte step: s = S[t[i] + k[i]], then fold into t[i+1]
   always_comb begin
      bi       = mode_ff ? ~cnt_ff[2:0] : cnt_ff[2:0];
      nx       = bi + 3'd1;
      t_i      = blk_ff[{bi, 3'b000} +: 8];
      k_i      = key_ff[{bi, 3'b000} +: 8];
      t_nx     = blk_ff[{nx, 3'b000} +: 8];
      s_val    = tbcp_pkg::SBOX[t_i + k_i];
      sum_enc  = s_val + t_nx;
      new_byte = mode_ff ? ({t_nx[0], t_nx[7:1]} - s_val) : {sum_enc[6:0], sum_enc[7]};
      step_blk = blk_ff;
      for (int j = 0; j < tbcp_pkg::BLK_BYTES; j++) begin
         if (nx == 3'(j)) step_blk[8*j +: 8] = new_byte;
      end
   end

   // pad a short encrypt block with the pad count
   always_comb begin
      n_sat    = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
      pad_byte = {4'd0, 4'd8 - n_sat};
      load_blk = req_block_in;
      for (int j = 0; j < tbcp_pkg::BLK_BYTES; j++) begin
         if (!mode_ff && (4'(j) >= n_sat)) load_blk[8*j +: 8] = pad_byte;
      end
   end

   // kept byte count: strip a valid pad from the final decrypted block
   always_comb begin
      pad_val    = blk_ff[tbcp_pkg::BLK_W-1 -: 8];
      emit_bytes = 4'd8;
      if (mode_ff && last_ff && (pad_val >= 8'd1) && (pad_val <= 8'd8)) begin
         emit_bytes = 4'd8 - pad_val[3:0];
      end
   end

   // register next values
   always_comb begin
      cnt_in       = cnt_ff;
      blk_in       = blk_ff;
      last_in      = last_ff;
      pad_in       = pad_ff;
      key_in       = key_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_block_in = rsp_block_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_last_in  = rsp_last_ff;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            tbcp_pkg::CSR_KEY:  key_in  = csr_wdata;
            tbcp_pkg::CSR_MODE: mode_in = csr_wdata[0];
            default:            key_in  = key_ff;
         endcase
      end

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      // load a new request
      if (accept) begin
         cnt_in  = '0;
         blk_in  = load_blk;
         last_in = mode_ff ? req_last_block : (n_sat != 4'd8);
         pad_in  = !mode_ff && (n_sat == 4'd8) && req_last_block;
      end

      // advance one byte step
      if (state_ff == tbcp_pkg::ST_RUN) begin
         cnt_in = cnt_ff + CNT_W'(1);
         blk_in = step_blk;
      end

      // emit the result, then start the padding block if one is owed
      if (do_emit) begin
         rsp_valid_in = 1'b1;
         rsp_block_in = blk_ff;
         rsp_bytes_in = emit_bytes;
         rsp_last_in  = last_ff;
         if (pad_ff) begin
            cnt_in  = '0;
            blk_in  = {tbcp_pkg::BLK_BYTES{tbcp_pkg::PAD_FULL}};
            last_in = 1'b1;
            pad_in  = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbcp_pkg::ST_IDLE;
         key_ff       <= tbcp_pkg::KEY_RESET;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pad_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_ff       <= key_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         pad_ff       <= pad_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      blk_ff       <= blk_in;
      last_ff      <= last_in;
      rsp_block_ff <= rsp_block_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_block_out   = rsp_block_ff;
   assign rsp_valid_bytes = rsp_bytes_ff;
   assign rsp_last_out    = rsp_last_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top: self-checking testbench for treyfer_block_crypt_padded
// Drives requests with random gaps and stalls the result side at random.
// Each accepted request is run through a local model of the cipher and its
// padding rules. Each result is compared with the oldest expected block.
// The run covers directed corner blocks, then padded encrypt and decrypt
// streams under several key and mode settings.
// -----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned BLK_W        = tbcp_pkg::BLK_W;
   localparam int unsigned ROUNDS       = 32;
   localparam int unsigned RANDOM_ITEMS = 1420;
   localparam int unsigned MAX_SHOWN    = 10;
   localparam logic [BLK_W-1:0] FULL_PAD_BLOCK = {8{8'h08}};

   typedef struct packed {
      logic [BLK_W-1:0] block;
      logic [3:0]       valid_bytes;
      logic             last;
   } block_result_type;

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_ready;
   logic [BLK_W-1:0] req_block_in   = '0;
   logic [3:0]       req_byte_count = '0;
   logic             req_last_block = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready      = 1'b0;
   logic [BLK_W-1:0] rsp_block_out;
   logic [3:0]       rsp_valid_bytes;
   logic             rsp_last_out;
   logic             csr_we         = 1'b0;
   logic             csr_index      = tbcp_pkg::CSR_KEY;
   logic [BLK_W-1:0] csr_wdata      = '0;

   // local copy of the substitution table and of the registers
   logic [7:0]       sbox_tbl [256];
   logic [BLK_W-1:0] model_key     = tbcp_pkg::KEY_RESET;
   logic             model_decrypt = 1'b0;

   block_result_type expected_blocks [$];
   int unsigned      error_count  = 0;
   int unsigned      items_sent   = 0;
   int unsigned      req_hold_gap = 0;
   bit               no_idle      = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   treyfer_block_crypt_padded #(
      .ROUNDS(ROUNDS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_block_in   (req_block_in),
      .req_byte_count (req_byte_count),
      .req_last_block (req_last_block),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_block_out  (rsp_block_out),
      .rsp_valid_bytes(rsp_valid_bytes),
      .rsp_last_out   (rsp_last_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // multiply in GF(2^8) modulo x^8 + x^4 + x^3 + x + 1
   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      acc = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return acc;
   endfunction

   // build the table from the field inverse and the affine map
   initial begin : build_sbox
      logic [7:0] inv;
      logic [7:0] s;
      for (int v = 0; v < 256; v++) begin
         inv = 8'h01;
         repeat (254) inv = gf_mul(inv, 8'(v));
         s = inv;
         for (int r = 1; r <= 4; r++) s ^= (inv << r) | (inv >> (8 - r));
         sbox_tbl[v] = s ^ 8'h63;
      end
   end

   function automatic logic [BLK_W-1:0] rand_block();
      return {$urandom, $urandom};
   endfunction

   // replace bytes n..7 with the pad count
   function automatic logic [BLK_W-1:0] pad_block(logic [BLK_W-1:0] blk, int n);
      for (int i = n; i < 8; i++) blk[8*i +: 8] = 8'(8 - n);
      return blk;
   endfunction

   function automatic logic [BLK_W-1:0] treyfer_encipher(logic [BLK_W-1:0] blk,
                                                        logic [BLK_W-1:0] key);
      logic [7:0] t [8];
      logic [7:0] run;
      logic [7:0] idx;
      int         nx;
      for (int i = 0; i < 8; i++) t[i] = blk[8*i +: 8];
      run = t[0];
      for (int r = 0; r < ROUNDS; r++) begin
         for (int i = 0; i < 8; i++) begin
            nx    = (i + 1) % 8;
            idx   = run + key[8*i +: 8];
            run   = sbox_tbl[idx] + t[nx];
            run   = {run[6:0], run[7]};
            t[nx] = run;
         end
      end
      for (int i = 0; i < 8; i++) blk[8*i +: 8] = t[i];
      return blk;
   endfunction

   function automatic logic [BLK_W-1:0] treyfer_decipher(logic [BLK_W-1:0] blk,
                                                        logic [BLK_W-1:0] key);
      logic [7:0] t [8];
      logic [7:0] idx;
      logic [7:0] c;
      int         i;
      int         nx;
      for (int b = 0; b < 8; b++) t[b] = blk[8*b +: 8];
      // undo the byte steps in reverse order
      for (int r = 0; r < ROUNDS; r++) begin
         for (int j = 0; j < 8; j++) begin
            i     = 7 - j;
            nx    = (i + 1) % 8;
            idx   = t[i] + key[8*i +: 8];
            c     = t[nx];
            t[nx] = {c[0], c[7:1]} - sbox_tbl[idx];
         end
      end
      for (int b = 0; b < 8; b++) blk[8*b +: 8] = t[b];
      return blk;
   endfunction

   // queue the blocks that one request must produce
   function automatic void predict_results(logic [BLK_W-1:0] blk, logic [3:0] count,
                                           logic last);
      logic [BLK_W-1:0] plain;
      logic [7:0]       pad;
      logic [3:0]       keep;
      int               n;
      if (model_decrypt) begin
         plain = treyfer_decipher(blk, model_key);
         pad   = plain[63:56];
         keep  = (last && pad >= 1 && pad <= 8) ? 4'(8 - pad) : 4'd8;
         expected_blocks.push_back('{plain, keep, last});
      end else begin
         n = (count > 8) ? 8 : count;
         if (n < 8) begin
            expected_blocks.push_back('{treyfer_encipher(pad_block(blk, n), model_key),
                                        4'd8, 1'b1});
         end else begin
            expected_blocks.push_back('{treyfer_encipher(blk, model_key), 4'd8, 1'b0});
            if (last)
               expected_blocks.push_back('{treyfer_encipher(FULL_PAD_BLOCK, model_key),
                                           4'd8, 1'b1});
         end
      end
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 80) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 20);
      return $urandom_range(100, 600);
   endfunction

   // send one request; keep valid high when the next one follows at once
   task automatic send_block(input logic [BLK_W-1:0] blk, input logic [3:0] count,
                             input logic last);
      repeat (req_hold_gap) @(posedge clock);
      req_valid      <= 1'b1;
      req_block_in   <= blk;
      req_byte_count <= count;
      req_last_block <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_results(blk, count, last);
      items_sent++;
      req_hold_gap = pick_gap();
      if (req_hold_gap != 0) req_valid <= 1'b0;
   endtask

   // drop valid and wait until every expected block has arrived
   task automatic drain_results();
      if (req_hold_gap == 0) req_valid <= 1'b0;
      req_hold_gap = 0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // write both registers; upper bits of the mode word are junk
   task automatic set_config(input logic [BLK_W-1:0] key, input logic mode);
      logic [BLK_W-1:0] mode_word;
      mode_word    = rand_block();
      mode_word[0] = mode;
      csr_we    <= 1'b1;
      csr_index <= tbcp_pkg::CSR_KEY;
      csr_wdata <= key;
      @(posedge clock);
      csr_index <= tbcp_pkg::CSR_MODE;
      csr_wdata <= mode_word;
      @(posedge clock);
      csr_we <= 1'b0;
      model_key     = key;
      model_decrypt = mode;
   endtask

   task automatic send_encrypt_stream();
      int unsigned full_cnt;
      int unsigned pick;
      full_cnt = $urandom_range(0, 4);
      repeat (full_cnt) send_block(rand_block(), 4'd8, 1'b0);
      pick = $urandom_range(0, 99);
      if (pick < 40)
         send_block(rand_block(), 4'($urandom_range(0, 7)), 1'($urandom));
      else if (pick < 70)
         send_block(rand_block(), 4'd8, 1'b1);
      else if (pick < 85)
         send_block(rand_block(), 4'($urandom_range(9, 15)), 1'($urandom));
      else
         send_block(rand_block(), 4'($urandom), 1'($urandom));
   endtask

   // ciphertext of a well-formed padded stream, with some noise blocks
   task automatic send_decrypt_stream();
      int unsigned      full_cnt;
      logic [BLK_W-1:0] plain;
      full_cnt = $urandom_range(0, 4);
      repeat (full_cnt)
         send_block(treyfer_encipher(rand_block(), model_key), 4'($urandom), 1'b0);
      if ($urandom_range(0, 9) == 0) plain = rand_block();
      else plain = pad_block(rand_block(), $urandom_range(0, 7));
      send_block(treyfer_encipher(plain, model_key), 4'($urandom), 1'b1);
      if ($urandom_range(0, 7) == 0) send_block(rand_block(), 4'($urandom), 1'($urandom));
   endtask

   // encrypt with the reset key: full, short, saturated and final blocks
   task automatic test_reset_state();
      send_block('0, 4'd8, 1'b0);
      send_block('1, 4'd8, 1'b0);
      send_block('0, 4'd8, 1'b1);
      send_block('1, 4'd8, 1'b1);
      send_block(rand_block(), 4'd0, 1'b0);
      send_block(rand_block(), 4'd1, 1'b1);
      send_block(rand_block(), 4'd7, 1'b0);
      send_block(rand_block(), 4'd4, 1'b1);
      send_block(rand_block(), 4'd9, 1'b1);
      send_block('1, 4'd15, 1'b0);
      send_block(rand_block(), 4'd12, 1'b1);
      drain_results();
   endtask

   // decrypt: valid pads, a block that is all padding, invalid pads
   task automatic test_decrypt_padding();
      logic [7:0]       bad_pads [3] = '{8'h00, 8'h09, 8'hff};
      logic [BLK_W-1:0] plain;
      set_config(rand_block(), 1'b1);
      send_block(treyfer_encipher(pad_block(rand_block(), 0), model_key), 4'd8, 1'b1);
      send_block(treyfer_encipher(pad_block(rand_block(), 1), model_key), 4'd0, 1'b1);
      send_block(treyfer_encipher(pad_block(rand_block(), 7), model_key), 4'd15, 1'b1);
      foreach (bad_pads[i]) begin
         plain          = rand_block();
         plain[63:56]   = bad_pads[i];
         send_block(treyfer_encipher(plain, model_key), 4'($urandom), 1'b1);
      end
      send_block('0, 4'd8, 1'b0);
      send_block('1, 4'd3, 1'b0);
      send_block('1, 4'd8, 1'b1);
      send_block('0, 4'd5, 1'b1);
      drain_results();
   endtask

   // padded streams under changing key and mode, extremes first
   task automatic test_random_traffic();
      int unsigned      phase;
      int unsigned      goal;
      logic [BLK_W-1:0] key;
      phase = 0;
      goal  = items_sent + RANDOM_ITEMS;
      while (items_sent < goal) begin
         if (phase < 2) key = '0;
         else if (phase < 4) key = '1;
         else key = rand_block();
         set_config(key, (phase < 4) ? phase[0] : 1'($urandom));
         // one phase runs back to back on both sides
         no_idle = (phase == 5);
         repeat (30) begin
            if (model_decrypt) send_decrypt_stream();
            else send_encrypt_stream();
         end
         drain_results();
         phase++;
      end
      no_idle = 1'b0;
   endtask

   // result side: random stalls, compare each result with the oldest expectation
   initial begin : rsp_sink
      int unsigned      stall_left;
      block_result_type want;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               error_count++;
               if (error_count <= MAX_SHOWN)
                  $display("unexpected result: block %h valid_bytes %0d last %b",
                           rsp_block_out, rsp_valid_bytes, rsp_last_out);
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_block_out !== want.block || rsp_valid_bytes !== want.valid_bytes ||
                   rsp_last_out !== want.last) begin
                  error_count++;
                  if (error_count <= MAX_SHOWN)
                     $display("mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                              want.block, want.valid_bytes, want.last,
                              rsp_block_out, rsp_valid_bytes, rsp_last_out);
               end
            end
            stall_left = pick_gap();
         end else if (stall_left != 0) begin
            stall_left--;
         end else if ($urandom_range(0, 149) == 0) begin
            stall_left = pick_gap();
         end
         rsp_ready <= (stall_left == 0);
      end
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_decrypt_padding();
      test_random_traffic();
      // hold a while so a stray result would still be caught
      repeat (300) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : watchdog
      #100_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
